[design/rle_pkg.sv]
// Package for the run-length encoder: sizes, payload and control types.
// Used by the top level, rle_plan and rle_ctrl; depends on nothing.
`timescale 1ns / 1ps

package rle_pkg;

	localparam int MAX_LITERAL = 32;
	localparam int MAX_REPEAT  = 127;

	localparam int LIT_AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
	localparam int CNT_W  = $clog2(MAX_LITERAL + 1);
	localparam int RUN_W  = $clog2(MAX_REPEAT + 1);

	localparam logic [CNT_W-1:0] LIT_FULL = CNT_W'(MAX_LITERAL);
	localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(MAX_REPEAT);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_burst;
	} out_beat_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [RUN_W-1:0] rc;
		logic [7:0]       pend;
		logic [7:0]       data;
		logic             last;
	} ctx_t;

	typedef struct packed {
		logic              en;
		logic [LIT_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		mem_wr_t           wr;
		logic              late_wr;
		logic [LIT_AW-1:0] late_addr;
		logic [7:0]        late_data;
		logic              do_g1;
		logic [CNT_W-1:0]  g1_n;
		logic              do_run;
		logic [RUN_W-1:0]  run_cnt;
		logic [7:0]        run_sym;
		logic              do_g2;
		logic [CNT_W-1:0]  g2_n;
		logic [CNT_W-1:0]  cnt_next;
		logic [RUN_W-1:0]  rc_next;
		logic [7:0]        pend_next;
	} plan_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EVAL  = 7'b0000010,
		ST_LHDR  = 7'b0000100,
		ST_LDAT  = 7'b0001000,
		ST_RCNT  = 7'b0010000,
		ST_RSYM  = 7'b0100000,
		ST_WLATE = 7'b1000000
	} seq_state_t;

endpackage

[design/rle_literal_run_encoder.sv]
// Top level of the byte-stream run-length encoder.
// Depends on rle_pkg, rle_ram, rle_plan and rle_ctrl.
`timescale 1ns / 1ps

// The encoder takes one byte per input beat and sends runs as a count followed by the
// symbol, and other bytes as a negated count followed by up to 32 stored bytes. Each
// byte is accepted in ST_IDLE and then evaluated in ST_EVAL against the pending run,
// where the literal store is written. The output beats then follow: a run as its count
// and symbol, a literal group as its header and then its bytes, read one entry a cycle
// from the literal store while the output register can take a beat; a final byte that
// differs from a lone pending byte puts both bytes into the store, the second store
// write taking a state of its own (ST_WLATE). A new byte is accepted only once the
// previous one has been fully sent into the output register.

module rle_literal_run_encoder import rle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	ctx_t              ctx;
	plan_t             plan;
	mem_wr_t           mem_wr;
	logic [LIT_AW-1:0] rd_addr;
	logic [7:0]        rd_data;

	rle_plan u_plan (
		.ctx  (ctx),
		.plan (plan)
	);

	rle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.ctx       (ctx),
		.plan      (plan),
		.mem_wr    (mem_wr),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	rle_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LITERAL)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr.en),
		.wr_addr (mem_wr.addr),
		.wr_data (mem_wr.data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

[design/rle_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; depends on nothing.
`timescale 1ns / 1ps

module rle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/rle_plan.sv]
// Decision logic: works out, from the encoder state and the new byte, which groups
// go out, which store writes happen and the next state. Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_plan import rle_pkg::*; (
	input  ctx_t  ctx,
	output plan_t plan
);

	logic             is_new;
	logic             is_eq;
	logic             is_one;
	logic             w1;
	logic             w2;
	logic [CNT_W-1:0] cnt_inc;
	logic             g1_b;
	logic             g1_c;
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] cnt2;
	logic             run_c;
	logic             run_s2;
	logic             run_l;
	logic [RUN_W-1:0] rc2;
	logic [RUN_W-1:0] rc3;
	logic [7:0]       pend2;

	always_comb begin
		is_new  = ctx.rc == '0;
		is_eq   = !is_new && (ctx.data == ctx.pend);
		is_one  = ctx.rc == RUN_W'(1);
		w1      = !is_new && !is_eq && is_one;
		cnt_inc = ctx.cnt + CNT_W'(1);
		g1_b    = is_eq && is_one && (ctx.cnt != '0);
		g1_c    = w1 && (cnt_inc == LIT_FULL);
		if (g1_b || g1_c) begin
			cnt1 = '0;
		end else if (w1) begin
			cnt1 = cnt_inc;
		end else begin
			cnt1 = ctx.cnt;
		end
		run_c  = !is_new && !is_eq && !is_one;
		rc2    = is_eq ? ctx.rc + RUN_W'(1) : RUN_W'(1);
		pend2  = is_eq ? ctx.pend : ctx.data;
		run_s2 = rc2 == RUN_FULL;
		rc3    = run_s2 ? '0 : rc2;
		w2     = ctx.last && (rc3 == RUN_W'(1));
		cnt2   = w2 ? cnt1 + CNT_W'(1) : cnt1;
		run_l  = ctx.last && (rc3 != '0) && (rc3 != RUN_W'(1));

		plan.wr.en        = w1 || w2;
		plan.wr.addr      = w1 ? ctx.cnt[LIT_AW-1:0] : cnt1[LIT_AW-1:0];
		plan.wr.data      = w1 ? ctx.pend : pend2;
		plan.late_wr      = w1 && w2;
		plan.late_addr    = cnt1[LIT_AW-1:0];
		plan.late_data    = pend2;
		plan.do_g1        = g1_b || g1_c;
		plan.g1_n         = g1_b ? ctx.cnt : LIT_FULL;
		plan.do_run       = run_c || run_s2 || run_l;
		if (run_c) begin
			plan.run_cnt = ctx.rc;
		end else if (run_s2) begin
			plan.run_cnt = RUN_FULL;
		end else begin
			plan.run_cnt = rc3;
		end
		plan.run_sym      = run_c ? ctx.pend : pend2;
		plan.do_g2        = ctx.last && (cnt2 != '0);
		plan.g2_n         = cnt2;
		plan.cnt_next     = ctx.last ? '0 : cnt1;
		plan.rc_next      = ctx.last ? '0 : rc3;
		plan.pend_next    = ctx.last ? '0 : pend2;
	end

endmodule

[design/rle_ctrl.sv]
// Sequencer: takes input beats, applies the decision, drives the literal store
// and sends groups through the output register. Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_ctrl import rle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_beat_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_beat_t         out_data,
	output ctx_t              ctx,
	input  plan_t             plan,
	output mem_wr_t           mem_wr,
	output logic [LIT_AW-1:0] rd_addr,
	input  logic [7:0]        rd_data
);

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [RUN_W-1:0]  rc_q;
	logic [7:0]        pend_q;
	logic [7:0]        data_q;
	logic              last_q;
	logic              g1_q;
	logic              run_q;
	logic              late_q;
	logic              g2_q;
	logic [CNT_W-1:0]  g1_n_q;
	logic [CNT_W-1:0]  g2_n_q;
	logic [RUN_W-1:0]  run_cnt_q;
	logic [7:0]        run_sym_q;
	logic [LIT_AW-1:0] late_addr_q;
	logic [7:0]        late_data_q;
	logic [LIT_AW-1:0] idx_q;
	logic              out_valid_q;
	out_beat_t         out_q;
	logic              can_emit;
	logic              emit;
	out_beat_t         beat;
	logic [CNT_W-1:0]  grp_n;
	logic              grp_end;

	function automatic seq_state_t pick(input logic g1, input logic run,
			input logic late, input logic g2);
		if (g1) begin
			return ST_LHDR;
		end else if (run) begin
			return ST_RCNT;
		end else if (late) begin
			return ST_WLATE;
		end else if (g2) begin
			return ST_LHDR;
		end
		return ST_IDLE;
	endfunction

	assign ctx       = '{cnt: cnt_q, rc: rc_q, pend: pend_q, data: data_q, last: last_q};
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		can_emit = !out_valid_q || out_ready;
		grp_n    = g1_q ? g1_n_q : g2_n_q;
		grp_end  = (CNT_W'(idx_q) + CNT_W'(1)) == grp_n;
		emit     = 1'b0;
		beat     = '0;
		state_d  = state_q;
		rd_addr  = idx_q;
		mem_wr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				mem_wr  = plan.wr;
				state_d = pick(plan.do_g1, plan.do_run, plan.late_wr, plan.do_g2);
			end
			ST_LHDR: begin
				rd_addr = '0;
				if (can_emit) begin
					emit           = 1'b1;
					beat.code_byte = 8'd0 - 8'(grp_n);
					state_d        = ST_LDAT;
				end
			end
			ST_LDAT: begin
				if (can_emit) begin
					emit           = 1'b1;
					beat.code_byte = rd_data;
					rd_addr        = idx_q + LIT_AW'(1);
					if (grp_end) begin
						beat.end_of_burst = g1_q ? !(run_q || g2_q) : 1'b1;
						state_d = g1_q ? pick(1'b0, run_q, late_q, g2_q) : ST_IDLE;
					end
				end
			end
			ST_RCNT: begin
				if (can_emit) begin
					emit           = 1'b1;
					beat.code_byte = 8'(run_cnt_q);
					state_d        = ST_RSYM;
				end
			end
			ST_RSYM: begin
				if (can_emit) begin
					emit              = 1'b1;
					beat.code_byte    = run_sym_q;
					beat.end_of_burst = !g2_q;
					state_d           = pick(1'b0, 1'b0, late_q, g2_q);
				end
			end
			ST_WLATE: begin
				mem_wr  = '{en: 1'b1, addr: late_addr_q, data: late_data_q};
				state_d = pick(1'b0, 1'b0, 1'b0, g2_q);
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rc_q        <= '0;
			pend_q      <= '0;
			g1_q        <= 1'b0;
			run_q       <= 1'b0;
			late_q      <= 1'b0;
			g2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL) begin
				cnt_q  <= plan.cnt_next;
				rc_q   <= plan.rc_next;
				pend_q <= plan.pend_next;
				g1_q   <= plan.do_g1;
				run_q  <= plan.do_run;
				late_q <= plan.late_wr;
				g2_q   <= plan.do_g2;
			end
			if (state_q == ST_LDAT && can_emit && grp_end) begin
				g1_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			data_q <= in_data.data_byte;
			last_q <= in_data.final_byte;
		end
		if (state_q == ST_EVAL) begin
			g1_n_q      <= plan.g1_n;
			g2_n_q      <= plan.g2_n;
			run_cnt_q   <= plan.run_cnt;
			run_sym_q   <= plan.run_sym;
			late_addr_q <= plan.late_addr;
			late_data_q <= plan.late_data;
		end
		if (state_q == ST_LHDR) begin
			idx_q <= '0;
		end else if (state_q == ST_LDAT && can_emit) begin
			idx_q <= idx_q + LIT_AW'(1);
		end
		if (emit) begin
			out_q <= beat;
		end
	end

endmodule

[tb/rle_literal_run_encoder_tb.sv]
// Self-checking testbench for the run-length encoder: it drives byte streams and
// compares every code beat with its own encoding of the accepted bytes.
// Depends on rle_pkg and rle_literal_run_encoder.
`timescale 1ns / 1ps

module rle_literal_run_encoder_tb;
	import rle_pkg::*;

	localparam int ITEM_TARGET  = 410;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 300;
	localparam int PHASE1_AT    = 140;
	localparam int PHASE2_AT    = 280;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_beat_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	in_beat_t  stim_q[$];
	out_beat_t pending_codes[$];

	logic [7:0]  lit_mem [MAX_LITERAL];
	int unsigned lit_cnt = 0;
	logic [7:0]  run_sym = 8'h00;
	int unsigned run_len = 0;
	out_beat_t   burst[$];

	logic [7:0] prev_byte;
	int         stream_count;
	int         items_accepted;
	int         codes_checked = 0;
	int         fault_count   = 0;
	int         cycle_cnt     = 0;
	int         hold_left;
	logic       hold_done;

	rle_literal_run_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #10 clk = ~clk;

	task automatic put_code(input logic [7:0] code);
		out_beat_t b;
		b.code_byte    = code;
		b.end_of_burst = 1'b0;
		burst.push_back(b);
	endtask

	task automatic send_literal_group();
		int unsigned i;
		if (lit_cnt == 0)
			return;
		put_code(8'(256 - lit_cnt));
		for (i = 0; i < lit_cnt && i < MAX_LITERAL; i++)
			put_code(lit_mem[i]);
		lit_cnt = 0;
	endtask

	task automatic store_literal(input logic [7:0] v);
		if (lit_cnt < MAX_LITERAL)
			lit_mem[lit_cnt] = v;
		lit_cnt++;
		if (lit_cnt >= MAX_LITERAL)
			send_literal_group();
	endtask

	task automatic send_run_group();
		put_code(8'(run_len));
		put_code(run_sym);
		run_len = 0;
	endtask

	task automatic encode_byte(input in_beat_t beat);
		logic [7:0] b;
		int         i;
		b = beat.data_byte;
		burst.delete();
		if (run_len == 0) begin
			run_sym = b;
			run_len = 1;
		end else if (b == run_sym) begin
			if (run_len == 1)
				send_literal_group();
			run_len++;
		end else begin
			if (run_len == 1)
				store_literal(run_sym);
			else
				send_run_group();
			run_sym = b;
			run_len = 1;
		end
		if (run_len >= MAX_REPEAT)
			send_run_group();
		if (beat.final_byte) begin
			if (run_len == 1) begin
				run_len = 0;
				store_literal(run_sym);
			end else if (run_len >= 2) begin
				send_run_group();
			end
			send_literal_group();
			run_len = 0;
			lit_cnt = 0;
			run_sym = 8'h00;
		end
		for (i = 0; i < burst.size(); i++) begin
			if (i == burst.size() - 1)
				burst[i].end_of_burst = 1'b1;
			pending_codes.push_back(burst[i]);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		in_beat_t beat;
		beat.data_byte  = b;
		beat.final_byte = last;
		stim_q.push_back(beat);
		prev_byte = b;
		if (last)
			stream_count++;
	endtask

	function automatic logic [7:0] other_than(input logic [7:0] v);
		return v ^ 8'($urandom_range(1, 255));
	endfunction

	task automatic queue_run_stream(input int len);
		logic [7:0] b;
		int         i;
		b = 8'($urandom);
		for (i = 0; i < len; i++)
			queue_byte(b, i == len - 1);
	endtask

	task automatic queue_literal_stream(input int len);
		int i;
		for (i = 0; i < len; i++)
			queue_byte(other_than(prev_byte), i == len - 1);
	endtask

	task automatic queue_mixed_stream();
		int         len;
		int         made;
		int         seg;
		int         k;
		int         i;
		logic [7:0] b;
		len  = $urandom_range(1, 40);
		made = 0;
		while (made < len) begin
			seg = $urandom_range(2);
			k   = 1;
			if (seg == 0) begin
				b = 8'($urandom);
				k = $urandom_range(2, 6);
			end else if (seg == 1) begin
				b = other_than(prev_byte);
			end else begin
				b = 8'($urandom_range(3));
			end
			for (i = 0; i < k && made < len; i++) begin
				queue_byte(b, made == len - 1);
				made++;
			end
		end
	endtask

	task automatic report_fault(input string what, input out_beat_t want, input out_beat_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("Mismatch (%s) at %0t: expected code %02h end %0b, got code %02h end %0b",
				what, $time, want.code_byte, want.end_of_burst,
				got.code_byte, got.end_of_burst);
	endtask

	function automatic int send_idle_pct();
		if (items_accepted < PHASE1_AT)
			return 10;
		if (items_accepted < PHASE2_AT)
			return 68;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (items_accepted < PHASE1_AT)
			return 68;
		if (items_accepted < PHASE2_AT)
			return 10;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			in_data        <= '0;
			items_accepted <= 0;
		end else begin
			if (in_valid && in_ready) begin
				encode_byte(in_data);
				items_accepted <= items_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					in_valid <= 1'b1;
					in_data  <= stim_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			codes_checked <= codes_checked + 1;
			if (pending_codes.size() == 0) begin
				report_fault("no beat expected", '0, out_data);
			end else begin
				want = pending_codes.pop_front();
				if (out_data.code_byte !== want.code_byte ||
						out_data.end_of_burst !== want.end_of_burst)
					report_fault("wrong field", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d beats outstanding.",
				cycle_cnt, pending_codes.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		prev_byte     = 8'h00;
		stream_count  = 0;

		// Lone byte, short run, literals before a run, literals only, and a lone byte
		// left over after a run.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h12, 1'b0);
		queue_byte(8'h34, 1'b0);
		queue_byte(8'h56, 1'b0);
		queue_byte(8'h56, 1'b1);
		queue_byte(8'hAA, 1'b0);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hAA, 1'b1);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h02, 1'b1);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h80, 1'b1);

		// A run that reaches the maximum on its final byte leaves nothing to flush,
		// and a final byte that completes a full literal group leaves none either.
		queue_run_stream(MAX_REPEAT);
		queue_literal_stream(MAX_LITERAL);

		while (stim_q.size() < ITEM_TARGET) begin
			case ($urandom_range(99)) inside
				[0:7]:   queue_run_stream($urandom_range(120, 200));
				[8:21]:  queue_literal_stream($urandom_range(28, 70));
				default: queue_mixed_stream();
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Encoded %0d bytes in %0d streams, with long runs, full literal groups",
			items_accepted, stream_count);
		$display("and a %0d-cycle receiver hold-off; %0d code beats checked.",
			HOLD_CYCLES, codes_checked);
		if (fault_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches in total.", fault_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
